// ===== rtl/grns_pkg.sv =====
// Shared types, constants and the sequencer's program for the Gray-Scott Newton step.
// Used by gray_scott_reaction_newton_step; depends on nothing else.
`timescale 1ns / 1ps
package grns_pkg;

	localparam int FRAC_BITS_DEF  = 48;
	localparam int ITER_LIMIT_DEF = 64;
	localparam int DATA_W         = 64;
	localparam int RF_DEPTH       = 32;
	localparam int RF_AW          = 5;
	localparam int PC_W           = 7;
	localparam int ITER_W         = 7;

	// Operations of the shared arithmetic unit and of the sequencer.
	typedef enum logic [3:0] {
		OP_LDC,
		OP_ADD,
		OP_SUB,
		OP_NEG,
		OP_MUL,
		OP_DIV,
		OP_CALL,
		OP_RET,
		OP_BRM0,
		OP_NRM,
		OP_CHK,
		OP_LOOP,
		OP_DONE
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EXEC,
		ST_MUL,
		ST_MRND,
		ST_DIV,
		ST_WB,
		ST_DONE
	} state_t;

	typedef logic [RF_AW-1:0] rf_addr_t;
	typedef logic [PC_W-1:0]  pc_t;

	// Register file map.
	localparam rf_addr_t R_G   = 5'd0;
	localparam rf_addr_t R_K   = 5'd1;
	localparam rf_addr_t R_E   = 5'd2;
	localparam rf_addr_t R_H   = 5'd3;
	localparam rf_addr_t R_ONE = 5'd4;
	localparam rf_addr_t R_GK  = 5'd5;
	localparam rf_addr_t R_Z   = 5'd6;
	localparam rf_addr_t R_R0  = 5'd7;
	localparam rf_addr_t R_R1  = 5'd8;
	localparam rf_addr_t R_S0  = 5'd9;
	localparam rf_addr_t R_S1  = 5'd10;
	localparam rf_addr_t R_F0  = 5'd11;
	localparam rf_addr_t R_F1  = 5'd12;
	localparam rf_addr_t R_X0  = 5'd13;
	localparam rf_addr_t R_X1  = 5'd14;
	localparam rf_addr_t R_A   = 5'd15;
	localparam rf_addr_t R_B   = 5'd16;
	localparam rf_addr_t R_T0  = 5'd17;
	localparam rf_addr_t R_T1  = 5'd18;
	localparam rf_addr_t R_T2  = 5'd19;
	localparam rf_addr_t R_T3  = 5'd20;
	localparam rf_addr_t R_T4  = 5'd21;
	localparam rf_addr_t R_T5  = 5'd22;
	localparam rf_addr_t R_T6  = 5'd23;
	localparam rf_addr_t R_T7  = 5'd24;
	localparam rf_addr_t R_T8  = 5'd25;
	localparam rf_addr_t R_T9  = 5'd26;
	localparam rf_addr_t R_T10 = 5'd27;
	localparam rf_addr_t R_T11 = 5'd28;
	localparam rf_addr_t R_T12 = 5'd29;

	// Constant sources for a load, carried in the first operand field.
	localparam rf_addr_t C_G    = 5'd0;
	localparam rf_addr_t C_K    = 5'd1;
	localparam rf_addr_t C_E    = 5'd2;
	localparam rf_addr_t C_H    = 5'd3;
	localparam rf_addr_t C_ONE  = 5'd4;
	localparam rf_addr_t C_UIN  = 5'd5;
	localparam rf_addr_t C_VIN  = 5'd6;
	localparam rf_addr_t C_ZERO = 5'd7;

	// Configuration register indexes.
	localparam logic [2:0] REG_FEED   = 3'd0;
	localparam logic [2:0] REG_KILL   = 3'd1;
	localparam logic [2:0] REG_INVTS  = 3'd2;
	localparam logic [2:0] REG_HSTEP  = 3'd3;
	localparam logic [2:0] REG_METHOD = 3'd4;
	localparam logic [2:0] REG_ABSTOL = 3'd5;
	localparam logic [2:0] REG_RELSH  = 3'd6;
	localparam logic [2:0] REG_MAXIT  = 3'd7;

	// Program labels.
	localparam pc_t L_BE    = 7'd17;
	localparam pc_t L_LOOP  = 7'd35;
	localparam pc_t L_RATES = 7'd78;

	typedef struct packed {
		op_t      op;
		rf_addr_t dst;
		rf_addr_t a;
		rf_addr_t b;
		pc_t      tgt;
	} uop_t;

	function automatic uop_t mk(input op_t op, input rf_addr_t d, input rf_addr_t a,
			input rf_addr_t b, input pc_t t);
		uop_t u;
		u.op  = op;
		u.dst = d;
		u.a   = a;
		u.b   = b;
		u.tgt = t;
		return u;
	endfunction

	// The program: set-up, guess, first residual, Newton loop, reaction-rate subroutine.
	function automatic uop_t uop_at(input pc_t pc);
		uop_t u;
		unique case (pc)
			7'd0:  u = mk(OP_LDC,  R_G,   C_G,    R_Z,   7'd0);
			7'd1:  u = mk(OP_LDC,  R_K,   C_K,    R_Z,   7'd0);
			7'd2:  u = mk(OP_LDC,  R_E,   C_E,    R_Z,   7'd0);
			7'd3:  u = mk(OP_LDC,  R_H,   C_H,    R_Z,   7'd0);
			7'd4:  u = mk(OP_LDC,  R_ONE, C_ONE,  R_Z,   7'd0);
			7'd5:  u = mk(OP_LDC,  R_Z,   C_ZERO, R_Z,   7'd0);
			7'd6:  u = mk(OP_LDC,  R_R0,  C_UIN,  R_Z,   7'd0);
			7'd7:  u = mk(OP_LDC,  R_R1,  C_VIN,  R_Z,   7'd0);
			7'd8:  u = mk(OP_ADD,  R_GK,  R_G,    R_K,   7'd0);
			7'd9:  u = mk(OP_BRM0, R_Z,   R_Z,    R_Z,   L_BE);
			7'd10: u = mk(OP_ADD,  R_X0,  R_R0,   R_Z,   7'd0);
			7'd11: u = mk(OP_ADD,  R_X1,  R_R1,   R_Z,   7'd0);
			7'd12: u = mk(OP_CALL, R_Z,   R_Z,    R_Z,   L_RATES);
			7'd13: u = mk(OP_MUL,  R_T2,  R_H,    R_A,   7'd0);
			7'd14: u = mk(OP_ADD,  R_R0,  R_R0,   R_T2,  7'd0);
			7'd15: u = mk(OP_MUL,  R_T2,  R_H,    R_B,   7'd0);
			7'd16: u = mk(OP_ADD,  R_R1,  R_R1,   R_T2,  7'd0);
			7'd17: u = mk(OP_ADD,  R_X0,  R_R0,   R_Z,   7'd0);
			7'd18: u = mk(OP_ADD,  R_X1,  R_R1,   R_Z,   7'd0);
			7'd19: u = mk(OP_CALL, R_Z,   R_Z,    R_Z,   L_RATES);
			7'd20: u = mk(OP_MUL,  R_T2,  R_H,    R_A,   7'd0);
			7'd21: u = mk(OP_ADD,  R_S0,  R_R0,   R_T2,  7'd0);
			7'd22: u = mk(OP_MUL,  R_T2,  R_H,    R_B,   7'd0);
			7'd23: u = mk(OP_ADD,  R_S1,  R_R1,   R_T2,  7'd0);
			7'd24: u = mk(OP_ADD,  R_X0,  R_S0,   R_Z,   7'd0);
			7'd25: u = mk(OP_ADD,  R_X1,  R_S1,   R_Z,   7'd0);
			7'd26: u = mk(OP_CALL, R_Z,   R_Z,    R_Z,   L_RATES);
			7'd27: u = mk(OP_MUL,  R_T2,  R_H,    R_A,   7'd0);
			7'd28: u = mk(OP_SUB,  R_T2,  R_S0,   R_T2,  7'd0);
			7'd29: u = mk(OP_SUB,  R_F0,  R_T2,   R_R0,  7'd0);
			7'd30: u = mk(OP_MUL,  R_T2,  R_H,    R_B,   7'd0);
			7'd31: u = mk(OP_SUB,  R_T2,  R_S1,   R_T2,  7'd0);
			7'd32: u = mk(OP_SUB,  R_F1,  R_T2,   R_R1,  7'd0);
			7'd33: u = mk(OP_NRM,  R_Z,   R_F0,   R_F1,  7'd0);
			7'd34: u = mk(OP_CHK,  R_Z,   R_Z,    R_Z,   7'd0);
			7'd35: u = mk(OP_MUL,  R_T0,  R_S1,   R_S1,  7'd0);
			7'd36: u = mk(OP_MUL,  R_T1,  R_S0,   R_S1,  7'd0);
			7'd37: u = mk(OP_ADD,  R_T1,  R_T1,   R_T1,  7'd0);
			7'd38: u = mk(OP_ADD,  R_T2,  R_G,    R_T0,  7'd0);
			7'd39: u = mk(OP_NEG,  R_T2,  R_T2,   R_Z,   7'd0);
			7'd40: u = mk(OP_MUL,  R_T2,  R_T2,   R_E,   7'd0);
			7'd41: u = mk(OP_NEG,  R_T3,  R_T1,   R_Z,   7'd0);
			7'd42: u = mk(OP_MUL,  R_T3,  R_T3,   R_E,   7'd0);
			7'd43: u = mk(OP_MUL,  R_T4,  R_T0,   R_E,   7'd0);
			7'd44: u = mk(OP_SUB,  R_T5,  R_T1,   R_GK,  7'd0);
			7'd45: u = mk(OP_MUL,  R_T5,  R_T5,   R_E,   7'd0);
			7'd46: u = mk(OP_MUL,  R_T6,  R_H,    R_T2,  7'd0);
			7'd47: u = mk(OP_SUB,  R_T6,  R_ONE,  R_T6,  7'd0);
			7'd48: u = mk(OP_MUL,  R_T7,  R_H,    R_T3,  7'd0);
			7'd49: u = mk(OP_NEG,  R_T7,  R_T7,   R_Z,   7'd0);
			7'd50: u = mk(OP_MUL,  R_T8,  R_H,    R_T4,  7'd0);
			7'd51: u = mk(OP_NEG,  R_T8,  R_T8,   R_Z,   7'd0);
			7'd52: u = mk(OP_MUL,  R_T9,  R_H,    R_T5,  7'd0);
			7'd53: u = mk(OP_SUB,  R_T9,  R_ONE,  R_T9,  7'd0);
			7'd54: u = mk(OP_MUL,  R_T10, R_T6,   R_T9,  7'd0);
			7'd55: u = mk(OP_MUL,  R_T11, R_T7,   R_T8,  7'd0);
			7'd56: u = mk(OP_SUB,  R_T10, R_T10,  R_T11, 7'd0);
			7'd57: u = mk(OP_MUL,  R_T11, R_T9,   R_F0,  7'd0);
			7'd58: u = mk(OP_MUL,  R_T12, R_T7,   R_F1,  7'd0);
			7'd59: u = mk(OP_SUB,  R_T11, R_T11,  R_T12, 7'd0);
			7'd60: u = mk(OP_DIV,  R_T11, R_T11,  R_T10, 7'd0);
			7'd61: u = mk(OP_MUL,  R_T12, R_T6,   R_F1,  7'd0);
			7'd62: u = mk(OP_MUL,  R_T0,  R_T8,   R_F0,  7'd0);
			7'd63: u = mk(OP_SUB,  R_T12, R_T12,  R_T0,  7'd0);
			7'd64: u = mk(OP_DIV,  R_T12, R_T12,  R_T10, 7'd0);
			7'd65: u = mk(OP_SUB,  R_S0,  R_S0,   R_T11, 7'd0);
			7'd66: u = mk(OP_SUB,  R_S1,  R_S1,   R_T12, 7'd0);
			7'd67: u = mk(OP_ADD,  R_X0,  R_S0,   R_Z,   7'd0);
			7'd68: u = mk(OP_ADD,  R_X1,  R_S1,   R_Z,   7'd0);
			7'd69: u = mk(OP_CALL, R_Z,   R_Z,    R_Z,   L_RATES);
			7'd70: u = mk(OP_MUL,  R_T2,  R_H,    R_A,   7'd0);
			7'd71: u = mk(OP_SUB,  R_T2,  R_S0,   R_T2,  7'd0);
			7'd72: u = mk(OP_SUB,  R_F0,  R_T2,   R_R0,  7'd0);
			7'd73: u = mk(OP_MUL,  R_T2,  R_H,    R_B,   7'd0);
			7'd74: u = mk(OP_SUB,  R_T2,  R_S1,   R_T2,  7'd0);
			7'd75: u = mk(OP_SUB,  R_F1,  R_T2,   R_R1,  7'd0);
			7'd76: u = mk(OP_NRM,  R_Z,   R_F0,   R_F1,  7'd0);
			7'd77: u = mk(OP_LOOP, R_Z,   R_Z,    R_Z,   L_LOOP);
			7'd78: u = mk(OP_MUL,  R_T0,  R_X0,   R_X1,  7'd0);
			7'd79: u = mk(OP_MUL,  R_T0,  R_T0,   R_X1,  7'd0);
			7'd80: u = mk(OP_SUB,  R_T1,  R_ONE,  R_X0,  7'd0);
			7'd81: u = mk(OP_MUL,  R_T1,  R_G,    R_T1,  7'd0);
			7'd82: u = mk(OP_SUB,  R_T1,  R_T1,   R_T0,  7'd0);
			7'd83: u = mk(OP_MUL,  R_A,   R_T1,   R_E,   7'd0);
			7'd84: u = mk(OP_MUL,  R_T1,  R_GK,   R_X1,  7'd0);
			7'd85: u = mk(OP_SUB,  R_T1,  R_T0,   R_T1,  7'd0);
			7'd86: u = mk(OP_MUL,  R_B,   R_T1,   R_E,   7'd0);
			7'd87: u = mk(OP_RET,  R_Z,   R_Z,    R_Z,   7'd0);
			default: u = mk(OP_DONE, R_Z, R_Z,    R_Z,   7'd0);
		endcase
		return u;
	endfunction

endpackage

// ===== rtl/grns_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the register file of the Newton step; depends on nothing else.
`timescale 1ns / 1ps
module grns_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/gray_scott_reaction_newton_step.sv =====
// Top level of the Gray-Scott reaction Newton step: APB registers, stream ports,
// sequencer and shared arithmetic unit. Depends on grns_pkg and grns_ram.
//
// Channel  | Direction | Transaction
// s_*      | in        | one grid point: tdata = u_in, v_in
// m_*      | out       | one result: tdata = u_out, v_out, iterations_used; tuser = status
// APB      | in/out    | one register write or read, 64-bit data
//
// Each operation passes through fetch, execute and write back; a product also passes
// through the shared 32x32 multiplier, a quotient through the bit-serial divider.
// An item runs the set-up up to the first residual (method 1 adds an explicit Euler step
// first), then the Newton iterations.
// Reset clears the registers to their defaults and the sequencer to idle; the register
// file needs no clearing, as every entry is written before it is read.
// s_tready is high only while idle; a finished result waits in the output register.
`timescale 1ns / 1ps
module gray_scott_reaction_newton_step
	import grns_pkg::*;
#(
	parameter int FRAC_BITS      = FRAC_BITS_DEF,
	parameter int ITER_LIMIT_MAX = ITER_LIMIT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [5:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // u_in [63:0], v_in [127:64]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata,   // u_out [63:0], v_out [127:64], iterations_used [134:128]
	output logic         m_tuser    // status
);

	localparam logic [63:0] SMAX = {1'b0, {63{1'b1}}};
	localparam logic [63:0] SMIN = {1'b1, {63{1'b0}}};

	// Saturating helpers.
	function automatic logic [63:0] sadd_f(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
		return s[63:0];
	endfunction

	function automatic logic [63:0] ssub_f(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
		return s[63:0];
	endfunction

	function automatic logic [63:0] mag_f(input logic [63:0] a);
		return a[63] ? (~a + 64'd1) : a;
	endfunction

	function automatic logic [63:0] pack_f(input logic [63:0] m, input logic neg);
		if (neg) return m[63] ? SMIN : (~m + 64'd1);
		return m[63] ? SMAX : m;
	endfunction

	// Configuration registers.
	logic [62:0] feed_q, kill_q, invts_q, hstep_q;
	logic        method_q;
	logic [31:0] abstol_q;
	logic [5:0]  relsh_q;
	logic [6:0]  maxit_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_q   <= '0;
			kill_q   <= '0;
			invts_q  <= 63'(1) << FRAC_BITS;
			hstep_q  <= '0;
			method_q <= 1'b0;
			abstol_q <= 32'd1;
			relsh_q  <= 6'd40;
			maxit_q  <= 7'd50;
		end else if (cfg_wr) begin
			unique case (paddr[5:3])
				REG_FEED:   feed_q   <= pwdata[62:0];
				REG_KILL:   kill_q   <= pwdata[62:0];
				REG_INVTS:  invts_q  <= pwdata[62:0];
				REG_HSTEP:  hstep_q  <= pwdata[62:0];
				REG_METHOD: method_q <= pwdata[0];
				REG_ABSTOL: abstol_q <= pwdata[31:0];
				REG_RELSH:  relsh_q  <= pwdata[5:0];
				REG_MAXIT:  maxit_q  <= pwdata[6:0];
				default:    feed_q   <= feed_q;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (paddr[5:3])
			REG_FEED:   prdata = {1'b0, feed_q};
			REG_KILL:   prdata = {1'b0, kill_q};
			REG_INVTS:  prdata = {1'b0, invts_q};
			REG_HSTEP:  prdata = {1'b0, hstep_q};
			REG_METHOD: prdata = {63'd0, method_q};
			REG_ABSTOL: prdata = {32'd0, abstol_q};
			REG_RELSH:  prdata = {58'd0, relsh_q};
			REG_MAXIT:  prdata = {57'd0, maxit_q};
			default:    prdata = '0;
		endcase
	end

	// Sequencer and datapath registers.
	state_t             state_q, state_d;
	pc_t                pc_q, ret_q;
	logic [ITER_W-1:0]  iters_q;
	logic               status_q;
	logic [63:0]        uin_q, vin_q;
	logic [63:0]        norm_q, tol_q, res_q, s0_q, s1_q;
	logic [63:0]        ma_q, mb_q, rem_q, lo_q, qt_q;
	logic               neg_q;
	logic [127:0]       acc_q;
	logic [1:0]         mcnt_q;
	logic [5:0]         dcnt_q;
	logic               ovalid_q, ostat_q;
	logic [63:0]        ou_q, ov_q;
	logic [ITER_W-1:0]  oiter_q;

	uop_t        u;
	logic [63:0] rd_a, rd_b;
	logic        rf_we;
	logic        out_load;

	assign u = uop_at(pc_q);

	// Two copies of the register file give two read ports.
	grns_ram #(.WIDTH(DATA_W), .DEPTH(RF_DEPTH)) u_rf_a (
		.clk(clk), .we(rf_we), .waddr(u.dst), .wdata(res_q), .raddr(u.a), .rdata(rd_a)
	);
	grns_ram #(.WIDTH(DATA_W), .DEPTH(RF_DEPTH)) u_rf_b (
		.clk(clk), .we(rf_we), .waddr(u.dst), .wdata(res_q), .raddr(u.b), .rdata(rd_b)
	);

	// Operand magnitudes and divider set-up checks.
	logic [63:0] mag_a, mag_b, div_hi, div_lo;
	logic        div_zero, div_ovf, mul_last, div_last;

	assign mag_a    = mag_f(rd_a);
	assign mag_b    = mag_f(rd_b);
	assign div_hi   = mag_a >> (DATA_W - FRAC_BITS);
	assign div_lo   = mag_a << FRAC_BITS;
	assign div_zero = (mag_b == 64'd0);
	assign div_ovf  = (div_hi >= mag_b);
	assign mul_last = (mcnt_q == 2'd3);
	assign div_last = (dcnt_q == 6'd63);

	// Convergence checks and the clamped iteration limit.
	logic [ITER_W-1:0] lim, iters_n;
	logic              tiny, above, again;
	logic [63:0]       tol_n;

	always_comb begin
		if (maxit_q == 7'd0) begin
			lim = ITER_W'(1);
		end else if (maxit_q > ITER_W'(ITER_LIMIT_MAX)) begin
			lim = ITER_W'(ITER_LIMIT_MAX);
		end else begin
			lim = maxit_q;
		end
	end

	assign iters_n = iters_q + ITER_W'(1);
	assign tiny    = (norm_q < {32'd0, abstol_q});
	assign tol_n   = {32'd0, abstol_q} + (norm_q >> relsh_q);
	assign above   = (norm_q > tol_q);
	assign again   = above && (iters_n < lim);

	// Combinational results: loads, add, subtract, negate, and division by zero or overflow.
	logic [63:0] ldc_val, alu_res;

	always_comb begin
		unique case (u.a)
			C_G:     ldc_val = {1'b0, feed_q};
			C_K:     ldc_val = {1'b0, kill_q};
			C_E:     ldc_val = {1'b0, invts_q};
			C_H:     ldc_val = method_q ? {2'b0, hstep_q[62:1]} : {1'b0, hstep_q};
			C_ONE:   ldc_val = 64'd1 << FRAC_BITS;
			C_UIN:   ldc_val = uin_q;
			C_VIN:   ldc_val = vin_q;
			default: ldc_val = '0;
		endcase
	end

	always_comb begin
		unique case (u.op)
			OP_LDC:  alu_res = ldc_val;
			OP_ADD:  alu_res = sadd_f(rd_a, rd_b);
			OP_SUB:  alu_res = ssub_f(rd_a, rd_b);
			OP_NEG:  alu_res = (rd_a == SMIN) ? SMAX : (~rd_a + 64'd1);
			default: alu_res = div_zero ? ((mag_a == 64'd0) ? 64'd0 : (rd_a[63] ? SMIN : SMAX))
					: pack_f({64{1'b1}}, rd_a[63] ^ rd_b[63]);
		endcase
	end

	// Shared multiplier: one 32x32 partial product per cycle.
	logic [31:0]  mul_a32, mul_b32;
	logic [63:0]  pp;
	logic [127:0] pp_ext, pp_sh, rnd, qq;

	assign mul_a32 = mcnt_q[1] ? ma_q[63:32] : ma_q[31:0];
	assign mul_b32 = mcnt_q[0] ? mb_q[63:32] : mb_q[31:0];
	assign pp      = mul_a32 * mul_b32;
	assign pp_ext  = {64'd0, pp};

	always_comb begin
		unique case (mcnt_q)
			2'd0:    pp_sh = pp_ext;
			2'd3:    pp_sh = pp_ext << 64;
			default: pp_sh = pp_ext << 32;
		endcase
	end

	// Rounding to nearest, ties away from zero, then saturation.
	assign rnd = acc_q + (128'd1 << (FRAC_BITS - 1));
	assign qq  = rnd >> FRAC_BITS;

	// Restoring divider step.
	logic [63:0] div_rs, div_rn, div_qn;
	logic        div_take;

	assign div_rs   = {rem_q[62:0], lo_q[63]};
	assign div_take = rem_q[63] | (div_rs >= mb_q);
	assign div_rn   = div_take ? (div_rs - mb_q) : div_rs;
	assign div_qn   = {qt_q[62:0], div_take};

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_FETCH;
			ST_FETCH: state_d = ST_EXEC;
			ST_EXEC: begin
				unique case (u.op)
					OP_LDC, OP_ADD, OP_SUB, OP_NEG: state_d = ST_WB;
					OP_MUL:  state_d = ST_MUL;
					OP_DIV:  state_d = (div_zero || div_ovf) ? ST_WB : ST_DIV;
					OP_CHK:  state_d = tiny ? ST_DONE : ST_FETCH;
					OP_LOOP: state_d = again ? ST_FETCH : ST_DONE;
					OP_DONE: state_d = ST_DONE;
					default: state_d = ST_FETCH;
				endcase
			end
			ST_MUL:   if (mul_last) state_d = ST_MRND;
			ST_MRND:  state_d = ST_WB;
			ST_DIV:   if (div_last) state_d = ST_WB;
			ST_WB:    state_d = ST_FETCH;
			ST_DONE:  if (!ovalid_q || m_tready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		rf_we    = (state_q == ST_WB);
		out_load = (state_q == ST_DONE) && (!ovalid_q || m_tready);
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pc_q     <= '0;
			ret_q    <= '0;
			iters_q  <= '0;
			status_q <= 1'b0;
			mcnt_q   <= '0;
			dcnt_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					pc_q     <= '0;
					iters_q  <= '0;
					status_q <= 1'b0;
				end
				ST_EXEC: begin
					mcnt_q <= '0;
					dcnt_q <= '0;
					unique case (u.op)
						OP_CALL: begin
							ret_q <= pc_q + 7'd1;
							pc_q  <= u.tgt;
						end
						OP_RET:  pc_q <= ret_q;
						OP_BRM0: pc_q <= method_q ? (pc_q + 7'd1) : u.tgt;
						OP_NRM, OP_CHK: pc_q <= pc_q + 7'd1;
						OP_LOOP: begin
							iters_q  <= iters_n;
							status_q <= above;
							pc_q     <= u.tgt;
						end
						default: pc_q <= pc_q;
					endcase
				end
				ST_MUL:  mcnt_q <= mcnt_q + 2'd1;
				ST_DIV:  dcnt_q <= dcnt_q + 6'd1;
				ST_WB:   pc_q <= pc_q + 7'd1;
				default: pc_q <= pc_q;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			uin_q <= s_tdata[63:0];
			vin_q <= s_tdata[127:64];
		end
		if (out_load) begin
			ou_q    <= s0_q;
			ov_q    <= s1_q;
			oiter_q <= iters_q;
			ostat_q <= status_q;
		end
		unique case (state_q)
			ST_EXEC: begin
				res_q <= alu_res;
				ma_q  <= mag_a;
				mb_q  <= mag_b;
				neg_q <= rd_a[63] ^ rd_b[63];
				acc_q <= '0;
				rem_q <= div_hi;
				lo_q  <= div_lo;
				qt_q  <= '0;
				if (u.op == OP_NRM) begin
					norm_q <= (mag_a > mag_b) ? mag_a : mag_b;
				end
				if (u.op == OP_CHK) begin
					tol_q <= tol_n;
				end
			end
			ST_MUL:  acc_q <= acc_q + pp_sh;
			ST_MRND: res_q <= pack_f((|qq[127:64]) ? {64{1'b1}} : qq[63:0], neg_q);
			ST_DIV: begin
				rem_q <= div_rn;
				lo_q  <= lo_q << 1;
				qt_q  <= div_qn;
				if (div_last) begin
					res_q <= pack_f(div_qn, neg_q);
				end
			end
			ST_WB: begin
				if (u.dst == R_S0) s0_q <= res_q;
				if (u.dst == R_S1) s1_q <= res_q;
			end
			default: res_q <= res_q;
		endcase
	end

	// Result stream.
	assign m_tvalid = ovalid_q;
	assign m_tdata  = {1'b0, oiter_q, ov_q, ou_q};
	assign m_tuser  = ostat_q;

endmodule
